[design/assert_macros.svh]
// Assertion macros shared by the encoder RTL.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, off while reset is low.
`define CHSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define CHSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/chse_pkg.sv]
// Package of the context Huffman stream encoder: payload structs, opcodes,
// default parameters and fixed field widths. Depends on nothing.
`default_nettype none

package chse_pkg;

  localparam int SYMBOLS_DEF      = 128;
  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYM_W            = 7;
  localparam int CODE_W           = 32;
  localparam int LEN_W            = 6;
  localparam int SYM_RANGE        = 128;
  localparam logic [SYM_W-1:0] EOF_RESET = 7'd26;

  typedef enum logic [2:0] {
    OP_LOAD_REG = 3'd0,
    OP_LOAD_CTX = 3'd1,
    OP_SET_EN   = 3'd2,
    OP_ENCODE   = 3'd3,
    OP_END      = 3'd4
  } chse_op_t;

  typedef struct packed {
    logic [2:0]        operation;
    logic [SYM_W-1:0]  context_req;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              enable;
  } chse_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       stream_end;
  } chse_out_t;

  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } chse_code_t;

  // Looked-up codeword handed from the table stage to the packer.
  typedef struct packed {
    logic       valid;
    logic       is_end;
    chse_code_t code;
  } chse_lookup_t;

endpackage

`default_nettype wire

[design/context_huffman_stream_encoder_top.sv]
// Top level of the order-1 context Huffman stream encoder.
// Depends on chse_pkg, chse_tables and chse_packer.
//
//  channel  direction  ports                         moves
//  in       input      in_valid/in_ready/in_data     one request (load, enable, encode, end)
//  out      output     out_valid/out_ready/out_data  one packed byte
//  cfg      input      cfg_wr_en/cfg_wr_data         end-of-file symbol
//
// One request is taken per cycle while in_ready is high. Encode and end requests read
// the tables at acceptance and reach the packer in the next cycle; their bytes (up to
// five at a 32-bit code limit) leave one per cycle while out_ready is high, and the
// next request with bytes waits until the buffer frees. A request with no byte
// retires without waiting on the output, but any request waits at the input while
// the lookup stage holds one that the output blocks. Reset (rst_n low, synchronous)
// clears enables, context, pending bits and valids; code tables hold garbage.
`default_nettype none

module context_huffman_stream_encoder_top #(
  parameter int SYMBOLS      = chse_pkg::SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = chse_pkg::MAX_CODE_LEN_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  chse_pkg::chse_in_t         in_data,
  output logic                       out_valid,
  input  wire                        out_ready,
  output chse_pkg::chse_out_t        out_data,
  input  wire                        cfg_wr_en,
  input  wire [chse_pkg::SYM_W-1:0]  cfg_wr_data
);
  import chse_pkg::*;

  chse_lookup_t lookup;
  logic         retire;
  logic         accept;

  // Take a new request whenever the lookup stage is empty or drains now.
  assign in_ready = !lookup.valid || retire;
  assign accept   = in_valid && in_ready;

  chse_tables #(
    .SYMBOLS      (SYMBOLS),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_tables (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (in_data),
    .accept      (accept),
    .retire      (retire),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .lookup      (lookup)
  );

  // Hold bytes in the output buffer while the sink stalls; advance on each beat.
  chse_packer #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .lookup    (lookup),
    .retire    (retire),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[design/chse_tables.sv]
// Code tables, context enables, context tracking and the lookup stage.
// Depends on chse_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module chse_tables #(
  parameter int SYMBOLS      = chse_pkg::SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = chse_pkg::MAX_CODE_LEN_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  chse_pkg::chse_in_t           req,
  input  wire                          accept,
  input  wire                          retire,
  input  wire                          cfg_wr_en,
  input  wire [chse_pkg::SYM_W-1:0]    cfg_wr_data,
  output chse_pkg::chse_lookup_t       lookup
);
  import chse_pkg::*;

  localparam int IW = $clog2(SYMBOLS);
  localparam int AW = $clog2(SYMBOLS * SYMBOLS);

  function automatic logic [SYM_RANGE*IW-1:0] wrap_lut_f();
    logic [SYM_RANGE*IW-1:0] lut;
    lut = '0;
    for (int i = 0; i < SYM_RANGE; i++) begin
      lut[i*IW +: IW] = IW'(i % SYMBOLS);
    end
    return lut;
  endfunction

  localparam logic [SYM_RANGE*IW-1:0] WRAP_LUT = wrap_lut_f();

  chse_code_t reg_mem [SYMBOLS];
  chse_code_t ctx_mem [SYMBOLS*SYMBOLS];
  chse_code_t reg_rd_r;
  chse_code_t ctx_rd_r;

  logic [SYMBOLS-1:0] ctx_en_r;
  logic [IW-1:0]      prev_r;
  logic               seen_r;
  logic [SYM_W-1:0]   eof_r;
  logic               s1_v_r;
  logic               s1_end_r;
  logic               s1_ctx_r;

  logic             is_enc;
  logic             is_end;
  logic             use_code;
  logic [SYM_W-1:0] sym_sel;
  logic [IW-1:0]    sym_w;
  logic [IW-1:0]    ctx_w;
  logic [IW-1:0]    ctx_sel;
  logic [AW-1:0]    ctx_addr;
  chse_code_t       code_w;

  always_comb begin
    is_enc   = (req.operation == OP_ENCODE);
    is_end   = (req.operation == OP_END);
    use_code = is_enc || is_end;
    sym_sel  = is_end ? eof_r : req.symbol;
    sym_w    = WRAP_LUT[32'(sym_sel)*IW +: IW];
    ctx_w    = WRAP_LUT[32'(req.context_req)*IW +: IW];
    ctx_sel  = use_code ? prev_r : ctx_w;
    ctx_addr = AW'(ctx_sel) * AW'(SYMBOLS) + AW'(sym_w);
    code_w.bits = req.code_bits;
    // Saturate long lengths to the configured maximum.
    code_w.len  = ({1'b0, req.code_length} > 7'(MAX_CODE_LEN)) ?
                  LEN_W'(MAX_CODE_LEN) : req.code_length;
  end

  always_ff @(posedge clk) begin
    if (accept && (req.operation == OP_LOAD_REG)) begin
      reg_mem[sym_w] <= code_w;
    end
    if (accept && use_code) begin
      reg_rd_r <= reg_mem[sym_w];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req.operation == OP_LOAD_CTX)) begin
      ctx_mem[ctx_addr] <= code_w;
    end
    if (accept && use_code) begin
      ctx_rd_r <= ctx_mem[ctx_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_en_r <= '0;
      prev_r   <= '0;
      seen_r   <= 1'b0;
      eof_r    <= EOF_RESET;
      s1_v_r   <= 1'b0;
      s1_end_r <= 1'b0;
      s1_ctx_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        eof_r <= cfg_wr_data;
      end
      if (accept && (req.operation == OP_SET_EN)) begin
        ctx_en_r[ctx_w] <= req.enable;
      end
      if (accept && is_enc) begin
        prev_r <= sym_w;
        seen_r <= 1'b1;
      end else if (accept && is_end) begin
        prev_r <= '0;
        seen_r <= 1'b0;
      end
      if (accept && use_code) begin
        s1_v_r   <= 1'b1;
        s1_end_r <= is_end;
        s1_ctx_r <= seen_r && ctx_en_r[prev_r];
      end else if (retire) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_comb begin
    lookup.valid  = s1_v_r;
    lookup.is_end = s1_end_r;
    lookup.code   = s1_ctx_r ? ctx_rd_r : reg_rd_r;
  end

  `CHSE_ASSERT(a_s1_hold, clk, rst_n, (s1_v_r && !retire) |=> s1_v_r, "lookup dropped")
  `CHSE_ASSERT(a_end_clears_ctx, clk, rst_n, (accept && is_end) |=> (!seen_r && prev_r == '0),
               "end left context")

endmodule

`default_nettype wire

[design/chse_packer.sv]
// Bit packer: joins pending bits with a codeword, splits whole bytes into
// the output buffer and keeps the leftover bits. Depends on chse_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module chse_packer #(
  parameter int MAX_CODE_LEN = chse_pkg::MAX_CODE_LEN_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  chse_pkg::chse_lookup_t  lookup,
  output logic                    retire,
  output logic                    out_valid,
  input  wire                     out_ready,
  output chse_pkg::chse_out_t     out_data
);
  import chse_pkg::*;

  localparam int SW   = ((MAX_CODE_LEN + 7 + 7) / 8) * 8;
  localparam int MAXB = SW / 8;
  localparam int XW   = SW + CODE_W;
  localparam int NW   = $clog2(SW + 1);
  localparam int SHW  = $clog2(XW + 1);
  localparam int BW   = $clog2(MAXB + 1);

  logic [6:0]    pend_bits_r;
  logic [2:0]    pend_cnt_r;
  logic          buf_v_r;
  logic [SW-1:0] buf_data_r;
  logic [BW-1:0] buf_cnt_r;
  logic          buf_end_r;

  logic [NW-1:0] n;
  logic [XW-1:0] joined;
  logic [XW-1:0] aligned;
  logic [BW-1:0] nbytes;
  logic [6:0]    pend_bits_nxt;
  logic          buf_free;
  logic          beat;

  always_comb begin
    n       = NW'(pend_cnt_r) + NW'(lookup.code.len);
    joined  = (XW'(pend_bits_r) << lookup.code.len) |
              (XW'(lookup.code.bits) & ~({XW{1'b1}} << lookup.code.len));
    aligned = joined << (SHW'(XW) - SHW'(n));
    // An end flushes the partial byte padded with zeros.
    nbytes  = lookup.is_end ? BW'(((NW+1)'(n) + (NW+1)'(7)) >> 3) : BW'(n >> 3);
    pend_bits_nxt = joined[6:0] & ~(7'h7f << n[2:0]);
    beat     = buf_v_r && out_ready;
    buf_free = !buf_v_r || (out_ready && (buf_cnt_r == BW'(1)));
    retire   = lookup.valid && ((nbytes == '0) || buf_free);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      buf_v_r     <= 1'b0;
      buf_cnt_r   <= '0;
      buf_end_r   <= 1'b0;
    end else begin
      if (retire) begin
        pend_bits_r <= lookup.is_end ? 7'd0 : pend_bits_nxt;
        pend_cnt_r  <= lookup.is_end ? 3'd0 : n[2:0];
      end
      if (retire && (nbytes != '0)) begin
        buf_v_r    <= 1'b1;
        buf_data_r <= aligned[XW-1 -: SW];
        buf_cnt_r  <= nbytes;
        buf_end_r  <= lookup.is_end;
      end else if (beat) begin
        buf_data_r <= buf_data_r << 8;
        buf_cnt_r  <= buf_cnt_r - BW'(1);
        buf_v_r    <= (buf_cnt_r != BW'(1));
      end
    end
  end

  always_comb begin
    out_valid           = buf_v_r;
    out_data.out_byte   = buf_data_r[SW-1 -: 8];
    out_data.last       = (buf_cnt_r == BW'(1));
    out_data.stream_end = buf_end_r && (buf_cnt_r == BW'(1));
  end

  `CHSE_ASSERT(a_buf_nonempty, clk, rst_n, buf_v_r |-> (buf_cnt_r != '0), "empty buffer valid")
  `CHSE_ASSERT(a_end_flush, clk, rst_n, (retire && lookup.is_end) |=> (pend_cnt_r == 3'd0),
               "end left pending bits")
  `CHSE_ASSERT_ALWAYS(a_rst_idle, clk, (!rst_n) |=> !buf_v_r, "buffer valid after reset")

endmodule

`default_nettype wire
